### hw/rtl/bbc_pkg.sv
package bbc_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 64;
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Bracket characters
	localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
	localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_CURLY  = 2'd1,
		KIND_SQUARE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_OPEN  = 2'd1,
		OP_CLOSE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		CAUSE_NONE     = 3'd0,
		CAUSE_MISMATCH = 3'd1,
		CAUSE_EMPTY    = 3'd2,
		CAUSE_UNCLOSED = 3'd3,
		CAUSE_OVERFLOW = 3'd4
	} cause_t;

	// One classified byte on its way to the stack engine
	typedef struct packed {
		op_t   op;
		kind_t kind;
		logic  eos;
	} cmd_t;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

### hw/rtl/bbc_front.sv
module bbc_front (
	input  logic          sym_valid,
	output logic          sym_stall,
	input  logic [7:0]    symbol,
	input  logic          symbol_present,
	input  logic          end_of_string,
	input  bbc_pkg::q_status_t q_stat,
	output logic          push,
	output bbc_pkg::cmd_t push_cmd
);
	import bbc_pkg::*;

	// Hold the source off while the queue has no room
	assign sym_stall = q_stat.full;
	assign push      = sym_valid && !q_stat.full;

	// Classify the byte into a stack operation and bracket kind
	always_comb begin
		push_cmd.op   = OP_NONE;
		push_cmd.kind = KIND_ROUND;
		push_cmd.eos  = end_of_string;
		if (symbol_present) begin
			unique case (symbol)
				CH_OPEN_ROUND: begin
					push_cmd.op   = OP_OPEN;
					push_cmd.kind = KIND_ROUND;
				end
				CH_OPEN_CURLY: begin
					push_cmd.op   = OP_OPEN;
					push_cmd.kind = KIND_CURLY;
				end
				CH_OPEN_SQUARE: begin
					push_cmd.op   = OP_OPEN;
					push_cmd.kind = KIND_SQUARE;
				end
				CH_CLOSE_ROUND: begin
					push_cmd.op   = OP_CLOSE;
					push_cmd.kind = KIND_ROUND;
				end
				CH_CLOSE_CURLY: begin
					push_cmd.op   = OP_CLOSE;
					push_cmd.kind = KIND_CURLY;
				end
				CH_CLOSE_SQUARE: begin
					push_cmd.op   = OP_CLOSE;
					push_cmd.kind = KIND_SQUARE;
				end
				default: begin
					push_cmd.op   = OP_NONE;
					push_cmd.kind = KIND_ROUND;
				end
			endcase
		end
	end

endmodule

### hw/rtl/bbc_queue.sv
module bbc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bbc_pkg::cmd_t push_cmd,
	input  logic          pop,
	output bbc_pkg::cmd_t head,
	output bbc_pkg::q_status_t q_stat
);
	import bbc_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = entry_q[rd_ptr_q];

	// Store incoming transaction
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/bbc_back.sv
module bbc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  bbc_pkg::cmd_t head,
	input  bbc_pkg::q_status_t q_stat,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_stall,
	output logic          balanced,
	output logic [2:0]    fail_cause
);
	import bbc_pkg::*;

	// Stack: entry at level-1 mirrored in top_q, entry at level-2 kept in rd_q
	kind_t             stack_mem [STACK_DEPTH];
	kind_t             top_q;
	kind_t             rd_q;
	logic [LVL_W-1:0]  level_q;
	cause_t            fail_q;

	logic              res_valid_q;
	logic              res_bal_q;
	cause_t            res_cause_q;

	logic              can_out;
	logic              active;
	logic              is_open;
	logic              is_close;
	logic              ovf;
	logic              do_push;
	logic              do_pop;
	logic              err_empty;
	logic              err_mism;
	cause_t            cause_nxt;
	cause_t            res_cause;
	logic [LVL_W-1:0]  level_nxt;
	logic [LVL_W-1:0]  level_m2;
	logic [IDX_W-1:0]  rd_addr;

	// Take a command when a result slot is free or it makes no result
	assign can_out = !res_valid_q || !res_stall;
	assign pop     = !q_stat.empty && (!head.eos || can_out);

	// Decode the command against the stack top
	always_comb begin
		active    = pop && (fail_q == CAUSE_NONE);
		is_open   = active && (head.op == OP_OPEN);
		is_close  = active && (head.op == OP_CLOSE);
		ovf       = is_open && (level_q == LVL_W'(STACK_DEPTH));
		do_push   = is_open && !ovf;
		err_empty = is_close && (level_q == '0);
		err_mism  = is_close && (level_q != '0) && (top_q != head.kind);
		do_pop    = is_close && (level_q != '0) && (top_q == head.kind);

		priority if (!active) begin
			cause_nxt = fail_q;
		end else if (ovf) begin
			cause_nxt = CAUSE_OVERFLOW;
		end else if (err_empty) begin
			cause_nxt = CAUSE_EMPTY;
		end else if (err_mism) begin
			cause_nxt = CAUSE_MISMATCH;
		end else begin
			cause_nxt = CAUSE_NONE;
		end

		priority if (do_push) begin
			level_nxt = level_q + 1'b1;
		end else if (do_pop) begin
			level_nxt = level_q - 1'b1;
		end else begin
			level_nxt = level_q;
		end

		level_m2 = level_nxt - LVL_W'(2);
		rd_addr  = level_m2[IDX_W-1:0];

		priority if (cause_nxt != CAUSE_NONE) begin
			res_cause = cause_nxt;
		end else if (level_nxt != '0) begin
			res_cause = CAUSE_UNCLOSED;
		end else begin
			res_cause = CAUSE_NONE;
		end
	end

	// Write pushed kind, prefetch the entry under the new top
	always_ff @(posedge clk) begin
		if (do_push) begin
			stack_mem[level_q[IDX_W-1:0]] <= head.kind;
		end
		rd_q <= stack_mem[rd_addr];
	end

	// Track the top entry
	always_ff @(posedge clk) begin
		priority if (do_push) begin
			top_q <= head.kind;
		end else if (do_pop) begin
			top_q <= rd_q;
		end
	end

	// Update level and sticky cause; clear at end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			fail_q  <= CAUSE_NONE;
		end else if (pop) begin
			if (head.eos) begin
				level_q <= '0;
				fail_q  <= CAUSE_NONE;
			end else begin
				level_q <= level_nxt;
				fail_q  <= cause_nxt;
			end
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (can_out) begin
			res_valid_q <= pop && head.eos;
		end
	end

	always_ff @(posedge clk) begin
		if (can_out && pop && head.eos) begin
			res_bal_q   <= (res_cause == CAUSE_NONE);
			res_cause_q <= res_cause;
		end
	end

	assign res_valid  = res_valid_q;
	assign balanced   = res_bal_q;
	assign fail_cause = res_cause_q;

endmodule

### hw/rtl/bracket_balance_checker.sv
// Channel   Valid      Stall      Payload
// input     sym_valid  sym_stall  symbol[7:0], symbol_present, end_of_string
// result    res_valid  res_stall  balanced, fail_cause[2:0]
//
// One byte is taken per cycle while the command queue has room; the stack
// engine does one push or pop per cycle, with the entry under the top
// prefetched from the stack memory. An end-of-string waits behind the queue
// and for a free result register; its result is then registered.
// Reset (arst_n low) empties the stack and the command queue; no clearing pass.
// A stalled result holds the engine only at the next end-of-string; the
// four-entry command queue absorbs short stalls without stopping the input.
module bracket_balance_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sym_valid,
	output logic       sym_stall,
	input  logic [7:0] symbol,
	input  logic       symbol_present,
	input  logic       end_of_string,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       balanced,
	output logic [2:0] fail_cause
);
	import bbc_pkg::*;

	logic      push;
	logic      pop;
	cmd_t      push_cmd;
	cmd_t      head;
	q_status_t q_stat;

	bbc_front u_front (
		.sym_valid      (sym_valid),
		.sym_stall      (sym_stall),
		.symbol         (symbol),
		.symbol_present (symbol_present),
		.end_of_string  (end_of_string),
		.q_stat         (q_stat),
		.push           (push),
		.push_cmd       (push_cmd)
	);

	bbc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	bbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.balanced   (balanced),
		.fail_cause (fail_cause)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_eos_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.eos) |=> res_valid)
		else $error("end of string without result");

	a_bal_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (balanced == (fail_cause == CAUSE_NONE)))
		else $error("balanced flag disagrees with cause");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import bbc_pkg::*;

	localparam int ITEM_TARGET = 1250;
	localparam int IDLE_LIMIT  = 3000;
	localparam int TAIL_CYCLES = 12;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 40;

	typedef struct {
		logic [7:0] sym;
		logic       present;
		logic       eos;
		logic       drain;
	} sym_item_t;

	typedef struct {
		logic   bal;
		cause_t cause;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       sym_valid = 1'b0;
	logic       sym_stall;
	logic [7:0] symbol = 8'h00;
	logic       symbol_present = 1'b0;
	logic       end_of_string = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       balanced;
	logic [2:0] fail_cause;

	sym_item_t  symbol_q[$];
	verdict_t   verdict_q[$];
	logic [7:0] text_q[$];

	// predictor state
	kind_t      kind_stack[STACK_DEPTH];
	int         depth_now = 0;
	cause_t     first_fault = CAUSE_NONE;

	int         queued_syms = 0;
	int         errors = 0;
	int         results_taken = 0;
	int         idle_cycles = 0;
	int         burst_left = 0;
	int         gap_left = 0;
	int         rx_rate = 0;
	int         rx_phase_left = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;
	sym_item_t  cur;
	verdict_t   want;

	bracket_balance_checker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sym_valid      (sym_valid),
		.sym_stall      (sym_stall),
		.symbol         (symbol),
		.symbol_present (symbol_present),
		.end_of_string  (end_of_string),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.balanced       (balanced),
		.fail_cause     (fail_cause)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic kind_t kind_of(input logic [7:0] ch);
		case (ch)
		CH_OPEN_CURLY, CH_CLOSE_CURLY: begin
			return KIND_CURLY;
		end
		CH_OPEN_SQUARE, CH_CLOSE_SQUARE: begin
			return KIND_SQUARE;
		end
		default: begin
			return KIND_ROUND;
		end
		endcase
	endfunction

	function automatic logic [7:0] open_char(input kind_t k);
		case (k)
		KIND_CURLY:  return CH_OPEN_CURLY;
		KIND_SQUARE: return CH_OPEN_SQUARE;
		default:     return CH_OPEN_ROUND;
		endcase
	endfunction

	function automatic logic [7:0] close_char(input kind_t k);
		case (k)
		KIND_CURLY:  return CH_CLOSE_CURLY;
		KIND_SQUARE: return CH_CLOSE_SQUARE;
		default:     return CH_CLOSE_ROUND;
		endcase
	endfunction

	// Any bracket, open or close, of a random kind
	function automatic logic [7:0] any_bracket();
		kind_t k;
		k = kind_t'($urandom_range(0, 2));
		if ($urandom_range(0, 1) == 1) begin
			return open_char(k);
		end
		return close_char(k);
	endfunction

	// Random byte that is not a bracket; flipping bit 7 moves a bracket out of ASCII
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		case (b)
		CH_OPEN_ROUND, CH_OPEN_CURLY, CH_OPEN_SQUARE,
		CH_CLOSE_ROUND, CH_CLOSE_CURLY, CH_CLOSE_SQUARE: begin
			b = b ^ 8'h80;
		end
		default: begin
		end
		endcase
		return b;
	endfunction

	// Advance the bracket stack by one transaction; on end of string, queue the verdict
	task automatic track_brackets(input logic [7:0] ch, input logic present, input logic eos);
		verdict_t v;
		if (present && first_fault == CAUSE_NONE) begin
			case (ch)
			CH_OPEN_ROUND, CH_OPEN_CURLY, CH_OPEN_SQUARE: begin
				if (depth_now >= STACK_DEPTH) begin
					first_fault = CAUSE_OVERFLOW;
				end else begin
					kind_stack[depth_now] = kind_of(ch);
					depth_now++;
				end
			end
			CH_CLOSE_ROUND, CH_CLOSE_CURLY, CH_CLOSE_SQUARE: begin
				if (depth_now == 0) begin
					first_fault = CAUSE_EMPTY;
				end else if (kind_stack[depth_now - 1] != kind_of(ch)) begin
					first_fault = CAUSE_MISMATCH;
				end else begin
					depth_now--;
				end
			end
			default: begin
			end
			endcase
		end
		if (eos) begin
			v.cause = first_fault;
			if (v.cause == CAUSE_NONE && depth_now != 0) begin
				v.cause = CAUSE_UNCLOSED;
			end
			v.bal = (v.cause == CAUSE_NONE);
			verdict_q.insert(verdict_q.size(), v);
			depth_now = 0;
			first_fault = CAUSE_NONE;
		end
	endtask

	task automatic push_sym(input logic [7:0] ch, input logic present, input logic eos);
		sym_item_t it;
		it.sym = ch;
		it.present = present;
		it.eos = eos;
		it.drain = 1'b0;
		symbol_q.insert(symbol_q.size(), it);
		queued_syms++;
	endtask

	// Pause the sender until every pending verdict has come back
	task automatic push_drain();
		sym_item_t it;
		it.sym = 8'h00;
		it.present = 1'b0;
		it.eos = 1'b0;
		it.drain = 1'b1;
		symbol_q.insert(symbol_q.size(), it);
	endtask

	// Move the staged text out as one string, with absent bytes sprinkled in
	task automatic send_string();
		bit tail_empty;
		int n;
		n = text_q.size();
		tail_empty = (n == 0) || ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				push_sym(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			push_sym(text_q[i], 1'b1, !tail_empty && i == n - 1);
		end
		if (tail_empty) begin
			push_sym(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
		text_q.delete();
	endtask

	// Stage a well-nested string with some noise bytes in between
	task automatic build_nested(input int pairs, input int max_nest);
		kind_t open_kinds[$];
		kind_t k;
		int opened;
		opened = 0;
		while (opened < pairs || open_kinds.size() > 0) begin
			if ($urandom_range(0, 7) == 0) begin
				text_q.insert(text_q.size(), noise_byte());
			end
			if (opened < pairs && open_kinds.size() < max_nest &&
					(open_kinds.size() == 0 || $urandom_range(0, 1) == 1)) begin
				k = kind_t'($urandom_range(0, 2));
				open_kinds.insert(open_kinds.size(), k);
				text_q.insert(text_q.size(), open_char(k));
				opened++;
			end else begin
				k = open_kinds[$];
				open_kinds.delete(open_kinds.size() - 1);
				text_q.insert(text_q.size(), close_char(k));
			end
		end
	endtask

	// Stage a string that reaches the full stack depth, or goes past it
	task automatic build_extreme(input bit overflow);
		kind_t kinds[$];
		kind_t k;
		int n;
		n = overflow ? STACK_DEPTH + 1 + $urandom_range(0, 2) : STACK_DEPTH;
		for (int i = 0; i < n; i++) begin
			k = kind_t'($urandom_range(0, 2));
			kinds.insert(kinds.size(), k);
			text_q.insert(text_q.size(), open_char(k));
		end
		if (overflow) begin
			for (int i = 0; i < 4; i++) begin
				text_q.insert(text_q.size(), any_bracket());
			end
		end else begin
			while (kinds.size() > 0) begin
				k = kinds[$];
				kinds.delete(kinds.size() - 1);
				text_q.insert(text_q.size(), close_char(k));
			end
		end
	endtask

	// Stimulus
	initial begin
		int sel;
		int pos;
		int extremes_left;
		bit mid_drain;
		extremes_left = 4;
		mid_drain = 1'b0;

		// empty string: the bracket is not examined
		push_sym(CH_OPEN_ROUND, 1'b0, 1'b1);
		// all three kinds nested, framed by the smallest and largest bytes
		push_sym(8'h00, 1'b1, 1'b0);
		push_sym(CH_OPEN_ROUND, 1'b1, 1'b0);
		push_sym(CH_OPEN_SQUARE, 1'b1, 1'b0);
		push_sym(CH_OPEN_CURLY, 1'b1, 1'b0);
		push_sym(CH_CLOSE_CURLY, 1'b1, 1'b0);
		push_sym(CH_CLOSE_SQUARE, 1'b1, 1'b0);
		push_sym(CH_CLOSE_ROUND, 1'b1, 1'b0);
		push_sym(8'hFF, 1'b1, 1'b1);
		// wrong kind of close, then a byte after the failure
		push_sym(CH_OPEN_ROUND, 1'b1, 1'b0);
		push_sym(CH_CLOSE_SQUARE, 1'b1, 1'b0);
		push_sym(CH_CLOSE_ROUND, 1'b1, 1'b1);
		// close on an empty stack
		push_sym(CH_CLOSE_CURLY, 1'b1, 1'b1);
		// left open, closed by an absent byte
		push_sym(CH_OPEN_SQUARE, 1'b1, 1'b0);
		push_sym(CH_CLOSE_SQUARE, 1'b0, 1'b1);
		// high byte that looks like a close with bit 7 set, then two mismatched pairs
		push_sym(CH_OPEN_CURLY, 1'b1, 1'b0);
		push_sym(CH_CLOSE_CURLY ^ 8'h80, 1'b1, 1'b1);
		push_sym(CH_OPEN_ROUND, 1'b1, 1'b0);
		push_sym(CH_CLOSE_CURLY, 1'b1, 1'b1);
		push_sym(CH_OPEN_SQUARE, 1'b1, 1'b0);
		push_sym(CH_CLOSE_ROUND, 1'b1, 1'b1);
		push_drain();

		// random strings, mostly well nested
		while (queued_syms < ITEM_TARGET) begin
			if (!mid_drain && queued_syms > ITEM_TARGET * 2 / 3) begin
				push_drain();
				mid_drain = 1'b1;
			end
			sel = $urandom_range(0, 9);
			if (sel == 9 && extremes_left > 0) begin
				build_extreme(extremes_left[0]);
				extremes_left--;
			end else if (sel <= 5 || sel == 9) begin
				build_nested($urandom_range(0, 10), $urandom_range(1, 8));
			end else if (sel <= 7) begin
				build_nested($urandom_range(1, 8), $urandom_range(1, 6));
				pos = $urandom_range(0, text_q.size() - 1);
				case ($urandom_range(0, 2))
				0: text_q[pos] = any_bracket();
				1: text_q.delete(pos);
				default: text_q.push_front(any_bracket());
				endcase
			end else if (sel == 8) begin
				repeat ($urandom_range(1, 20)) begin
					if ($urandom_range(0, 1) == 1) begin
						text_q.insert(text_q.size(), any_bracket());
					end else begin
						text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
					end
				end
			end
			send_string();
		end

		while (!(symbol_q.size() == 0 && !sym_valid && verdict_q.size() == 0) &&
				idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
		end
		if (idle_cycles < IDLE_LIMIT) begin
			repeat (TAIL_CYCLES) @(posedge clk);
		end
		if (verdict_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, verdict_q.size());
			errors += verdict_q.size();
		end
		if (idle_cycles >= IDLE_LIMIT || errors != 0) begin
			$display("end of test: mismatches");
		end else begin
			$display("end of test: clean");
		end
		$finish;
	end

	// Driver: offer one transaction at a time, in bursts with gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			sym_valid <= 1'b0;
		end else begin
			if (sym_valid && !sym_stall) begin
				track_brackets(symbol, symbol_present, end_of_string);
			end
			if (!sym_valid || !sym_stall) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (symbol_q.size() > 0 && symbol_q[0].drain) begin
					sym_valid <= 1'b0;
					if (verdict_q.size() == 0) begin
						cur = symbol_q.pop_front();
					end
				end else if (gap_left > 0 || symbol_q.size() == 0) begin
					sym_valid <= 1'b0;
					if (gap_left > 0) begin
						gap_left--;
					end
				end else begin
					cur = symbol_q.pop_front();
					sym_valid <= 1'b1;
					symbol <= cur.sym;
					symbol_present <= cur.present;
					end_of_string <= cur.eos;
					burst_left--;
				end
			end
		end
	end

	// Receiver: stall at a rate that changes by phase, with one long hold
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (!hold_done && results_taken >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			res_stall <= 1'b1;
		end else begin
			if (rx_phase_left == 0) begin
				rx_rate = $urandom_range(0, 3);
				rx_phase_left = $urandom_range(20, 100);
			end
			rx_phase_left--;
			res_stall <= ($urandom_range(0, 3) < rx_rate);
		end
	end

	// Monitor: compare each result transaction with the oldest verdict
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			results_taken++;
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected result: balanced %0b cause %0d",
					$time, balanced, fail_cause);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (balanced !== want.bal) begin
					$display("%0t: balanced expected %0b actual %0b",
						$time, want.bal, balanced);
					errors++;
				end
				if (fail_cause !== want.cause) begin
					$display("%0t: fail_cause expected %0d actual %0d",
						$time, want.cause, fail_cause);
					errors++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((sym_valid && !sym_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
